// File: hw/rtl/wpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpm_pkg: shared definitions for the wildcard pattern matcher
// Capacity, index widths, glob symbol codes, item modes and the per-cycle
// control bundle broadcast from the top level to every matcher cell.
// ----------------------------------------------------------------------------
package wpm_pkg;

   // Pattern capacity and derived widths
   localparam int PATTERN_MAX = 64;
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

   // Glob symbols
   localparam logic [7:0] STAR_BYTE  = 8'd42;
   localparam logic [7:0] QMARK_BYTE = 8'd63;

   // Item modes
   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_TEXT   = 2'd2,
      MODE_IDLE   = 2'd3
   } wpm_mode_type;

   // Control bundle shared by all cells in one cycle
   typedef struct packed {
      logic             update;   // recompute the column this cycle
      logic             restart;  // empty-text column (else consume a text byte)
      logic             wr_en;    // store symbol into the cell at wr_len
      logic [LEN_W-1:0] wr_len;   // pattern length before the append
      logic [LEN_W-1:0] limit;    // pattern length that the new column uses
      logic [7:0]       symbol;   // pattern or text byte
   } wpm_ctrl_type;

endpackage
`default_nettype wire

// File: hw/rtl/wpm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpm_cell: one pattern position of the matcher chain
// Holds one pattern byte and one column bit. Takes the new and old column
// bits of its left neighbor, forms its own new bit, and passes the selected
// match bit on to the right.
// ----------------------------------------------------------------------------
module wpm_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire wpm_pkg::wpm_ctrl_type     ctrl,
   input  wire logic [wpm_pkg::LEN_W-1:0] cell_index,
   input  wire logic                      left_new,
   input  wire logic                      left_old,
   input  wire logic                      left_match,
   output logic                           new_bit,
   output logic                           old_bit,
   output logic                           match_out
);

   logic [7:0] pat_ff;
   logic [7:0] pat_in;
   logic       col_ff;
   logic       col_in;
   logic       write_here;
   logic       active;
   logic       p_star;
   logic       p_hit;
   logic       computed;

   // Capture the appended byte when this cell is the next free position
   always_comb begin
      write_here = ctrl.wr_en && (cell_index == ctrl.wr_len);
      pat_in     = write_here ? ctrl.symbol : pat_ff;
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
   end

   // Form the new column bit; positions beyond the pattern stay clear
   always_comb begin
      active = cell_index < ctrl.limit;
      p_star = pat_in == wpm_pkg::STAR_BYTE;
      p_hit  = (pat_in == wpm_pkg::QMARK_BYTE) || (pat_in == ctrl.symbol);
      if (ctrl.restart) begin
         computed = active && left_new && p_star;
      end else if (p_star) begin
         computed = active && (left_new || col_ff);
      end else begin
         computed = active && p_hit && left_old;
      end
      col_in = ctrl.update ? computed : col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
      end
   end

   // Pass the bit at the pattern end down the chain
   always_comb begin
      new_bit   = col_in;
      old_bit   = col_ff;
      match_out = ((cell_index + wpm_pkg::LEN_W'(1)) == ctrl.limit) ? col_in : left_match;
   end

endmodule
`default_nettype wire

// File: hw/rtl/wildcard_pattern_matcher_unit.sv
`default_nettype none
// Latency: a result is valid in the cycle after its request transaction is accepted.
// Throughput: one item per unstalled cycle; the star OR chain and the match select
// ripple through all PATTERN_MAX cells in that cycle, which sets the clock period.
// Reset: pattern length zero, column bit zero set and all cell bits clear; the
// pattern bytes are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_unit: streaming glob matcher top level
// Decodes clear, append and text items, drives the chain of matcher cells,
// and registers match and overflow for the response channel.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_mode,
   input  wire logic [7:0] req_symbol,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_match,
   output logic            rsp_overflow
);

   localparam int PMAX = wpm_pkg::PATTERN_MAX;
   localparam int LW   = wpm_pkg::LEN_W;

   logic                  accept;
   logic                  full;
   logic                  ovf;
   logic [LW-1:0]         length_ff;
   logic [LW-1:0]         length_in;
   logic                  col0_ff;
   logic                  col0_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_match_ff;
   logic                  rsp_overflow_ff;
   wpm_pkg::wpm_ctrl_type ctrl;
   logic [PMAX:0]         new_chain;
   logic [PMAX:0]         old_chain;
   logic [PMAX:0]         match_chain;

   // Take a transaction whenever the output register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = length_ff == LW'(PMAX);

   // Decode the item into length update and cell control
   always_comb begin
      length_in   = length_ff;
      col0_in     = col0_ff;
      ovf         = 1'b0;
      ctrl.update  = 1'b0;
      ctrl.restart = 1'b0;
      ctrl.wr_en   = 1'b0;
      ctrl.wr_len  = length_ff;
      ctrl.symbol  = req_symbol;
      unique case (wpm_pkg::wpm_mode_type'(req_mode))
         wpm_pkg::MODE_CLEAR: begin
            if (accept) begin
               length_in    = '0;
               col0_in      = 1'b1;
               ctrl.update  = 1'b1;
               ctrl.restart = 1'b1;
            end
         end
         wpm_pkg::MODE_APPEND: begin
            if (accept) begin
               col0_in      = 1'b1;
               ctrl.update  = 1'b1;
               ctrl.restart = 1'b1;
               if (full) begin
                  ovf = 1'b1;
               end else begin
                  length_in  = length_ff + LW'(1);
                  ctrl.wr_en = 1'b1;
               end
            end
         end
         wpm_pkg::MODE_TEXT: begin
            if (accept) begin
               col0_in     = 1'b0;
               ctrl.update = 1'b1;
            end
         end
         wpm_pkg::MODE_IDLE: begin
         end
         default: begin
         end
      endcase
      ctrl.limit = length_in;
   end

   // Hold pattern length and column bit zero
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         col0_ff   <= 1'b1;
      end else begin
         length_ff <= length_in;
         col0_ff   <= col0_in;
      end
   end

   // Seed the chain with column bit zero
   assign new_chain[0]   = col0_in;
   assign old_chain[0]   = col0_ff;
   assign match_chain[0] = col0_in;

   // Chain of matcher cells, one per pattern position
   for (genvar g = 0; g < PMAX; g++) begin : g_cell
      wpm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .cell_index (LW'(g)),
         .left_new   (new_chain[g]),
         .left_old   (old_chain[g]),
         .left_match (match_chain[g]),
         .new_bit    (new_chain[g+1]),
         .old_bit    (old_chain[g+1]),
         .match_out  (match_chain[g+1])
      );
   end

   // Output register: load on accept, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_match_ff    <= match_chain[PMAX];
         rsp_overflow_ff <= ovf;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_match    = rsp_match_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule
`default_nettype wire

// File: hw/rtl/wpm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpm_checker: port-level checks for the wildcard pattern matcher
// Watches the request and response channels and flags results that do not
// follow from the transaction that caused them.
// ----------------------------------------------------------------------------
module wpm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_mode,
   input wire logic [7:0] req_symbol,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_match,
   input wire logic       rsp_overflow
);

   logic req_take;
   assign req_take = req_valid && req_ready;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match) && $stable(rsp_overflow))
      else $error("stalled response changed");

   // Never take a request while a result waits unread
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken over a waiting response");

   // A clear always matches and never overflows
   a_clear_match: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_mode == wpm_pkg::MODE_CLEAR) |=> rsp_valid && rsp_match && !rsp_overflow)
      else $error("clear did not report an empty match");

   // Only an append can overflow
   a_ovf_append: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_mode != wpm_pkg::MODE_APPEND) |=> rsp_valid && !rsp_overflow)
      else $error("overflow on a non-append transaction");

   // Symbol is payload only; keep it observed for a stable request
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_symbol) && $stable(req_mode))
      else $error("stalled request changed");

endmodule

bind wildcard_pattern_matcher_unit wpm_checker u_wpm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_mode     (req_mode),
   .req_symbol   (req_symbol),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_match    (rsp_match),
   .rsp_overflow (rsp_overflow)
);
`default_nettype wire

// File: dv/wpm_checker.sv
// ----------------------------------------------------------------------------
// wpm_scoreboard: transaction checker for the wildcard pattern matcher
// Watches the request and response channels, keeps its own copy of the
// pattern bytes and the match column, predicts match and overflow for every
// accepted request, and compares each response with the oldest prediction.
// ----------------------------------------------------------------------------
module wpm_scoreboard (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [1:0] req_mode,
   input  wire logic [7:0] req_symbol,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic       rsp_match,
   input  wire logic       rsp_overflow,
   output int              errors,
   output int              pending,
   output int              results_checked,
   output int              match_count,
   output int              overflow_count
);

   typedef struct packed {
      logic match;
      logic overflow;
   } glob_verdict_type;

   // Shadow state of the matcher
   logic [7:0]                    pat_bytes [wpm_pkg::PATTERN_MAX];
   int                            pat_len;
   logic [wpm_pkg::PATTERN_MAX:0] glob_col;

   glob_verdict_type              verdict_queue [$];

   // Rebuild the column for the empty text: only leading stars can match it
   function automatic void restart_column();
      glob_col    = '0;
      glob_col[0] = 1'b1;
      for (int i = 1; i <= pat_len; i++) begin
         glob_col[i] = glob_col[i-1] && (pat_bytes[i-1] == wpm_pkg::STAR_BYTE);
      end
   endfunction

   // Apply one request to the shadow state and return the expected response
   function automatic glob_verdict_type predict_glob(input logic [1:0] mode_bits,
                                                     input logic [7:0] sym);
      glob_verdict_type              v;
      logic [wpm_pkg::PATTERN_MAX:0] next_col;
      logic [7:0]                    p;
      v = '0;
      case (wpm_pkg::wpm_mode_type'(mode_bits))
         wpm_pkg::MODE_CLEAR: begin
            pat_len = 0;
            restart_column();
         end
         wpm_pkg::MODE_APPEND: begin
            if (pat_len < wpm_pkg::PATTERN_MAX) begin
               pat_bytes[pat_len] = sym;
               pat_len++;
            end else begin
               v.overflow = 1'b1;
            end
            restart_column();
         end
         wpm_pkg::MODE_TEXT: begin
            // A pattern star stays a wildcard even against a star in the text
            next_col = '0;
            for (int i = 1; i <= pat_len; i++) begin
               p = pat_bytes[i-1];
               if (p == wpm_pkg::STAR_BYTE)
                  next_col[i] = next_col[i-1] | glob_col[i];
               else if (p == wpm_pkg::QMARK_BYTE || p == sym)
                  next_col[i] = glob_col[i-1];
            end
            glob_col = next_col;
         end
         default: ;
      endcase
      v.match = glob_col[pat_len];
      return v;
   endfunction

   // Compare responses first, then record the prediction for a new request
   always @(posedge clock) begin : watch
      glob_verdict_type want;
      glob_verdict_type fresh;
      int               bad;
      bad = 0;
      if (reset) begin
         pat_len  = 0;
         restart_column();
         verdict_queue.delete();
         errors          <= 0;
         pending         <= 0;
         results_checked <= 0;
         match_count     <= 0;
         overflow_count  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               $error("response transaction with no request outstanding");
               bad++;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_match !== want.match) begin
                  $error("match: expected %0b, got %0b", want.match, rsp_match);
                  bad++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_overflow);
                  bad++;
               end
               match_count    <= match_count + want.match;
               overflow_count <= overflow_count + want.overflow;
            end
            results_checked <= results_checked + 1;
         end
         if (req_valid && req_ready) begin
            fresh         = predict_glob(req_mode, req_symbol);
            verdict_queue = {verdict_queue, fresh};
         end
         errors  <= errors + bad;
         pending <= verdict_queue.size();
      end
   end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the wildcard pattern matcher
// Drives directed and random glob sessions (clear, pattern bytes, text bytes,
// full-store overflow, noise) with random gaps and receiver stalls; the
// scoreboard beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;

   localparam int ITEM_TARGET = 450;
   localparam int CYCLE_LIMIT = 300000;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_valid  = 1'b0;
   logic       req_ready;
   logic [1:0] req_mode   = wpm_pkg::MODE_IDLE;
   logic [7:0] req_symbol = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready  = 1'b0;
   logic       rsp_match;
   logic       rsp_overflow;

   int errors, pending, results_checked, match_count, overflow_count;
   int cycle_count = 0;
   int items_sent  = 0;
   int text_sent   = 0;
   int append_sent = 0;
   int idle_sent   = 0;
   bit burst       = 1'b0;

   wildcard_pattern_matcher_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_symbol   (req_symbol),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_match    (rsp_match),
      .rsp_overflow (rsp_overflow)
   );

   wpm_scoreboard u_scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_symbol      (req_symbol),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_match       (rsp_match),
      .rsp_overflow    (rsp_overflow),
      .errors          (errors),
      .pending         (pending),
      .results_checked (results_checked),
      .match_count     (match_count),
      .overflow_count  (overflow_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // End the run at a generous cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones, none during a burst
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 2);
      if (r < 98) return $urandom_range(3, 6);
      return $urandom_range(10, 30);
   endfunction

   // Pattern bytes lean on a small alphabet so that matches happen
   function automatic logic [7:0] pick_glob_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return 8'h61;
      if (r < 55) return 8'h62;
      if (r < 75) return wpm_pkg::STAR_BYTE;
      if (r < 90) return wpm_pkg::QMARK_BYTE;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_text_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 8'h61;
      if (r < 70) return 8'h62;
      if (r < 80) return wpm_pkg::STAR_BYTE;
      if (r < 85) return wpm_pkg::QMARK_BYTE;
      return 8'($urandom_range(0, 255));
   endfunction

   // Offer one transaction and hold it until accepted
   task automatic offer_item(input wpm_pkg::wpm_mode_type m, input logic [7:0] sym);
      int gap;
      req_valid  <= 1'b1;
      req_mode   <= m;
      req_symbol <= sym;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (m)
         wpm_pkg::MODE_TEXT:   text_sent++;
         wpm_pkg::MODE_APPEND: append_sent++;
         wpm_pkg::MODE_IDLE:   idle_sent++;
         default: ;
      endcase
      if (m != wpm_pkg::MODE_IDLE) items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering until every expected response has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Clear unless keep_pattern is set, build a short pattern, then stream text against it
   task automatic run_glob_session(input bit keep_pattern, input bit wild_text);
      int plen, tlen;
      plen = $urandom_range(1, 8);
      tlen = $urandom_range(0, 12);
      if (!keep_pattern) offer_item(wpm_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)));
      for (int i = 0; i < plen; i++) offer_item(wpm_pkg::MODE_APPEND, pick_glob_byte());
      for (int i = 0; i < tlen; i++)
         offer_item(wpm_pkg::MODE_TEXT,
                    wild_text ? 8'($urandom_range(0, 255)) : pick_text_byte());
   endtask

   // Fill the store past capacity, then stream a long text
   task automatic run_fill_session();
      int r;
      offer_item(wpm_pkg::MODE_CLEAR, 8'h00);
      for (int i = 0; i < wpm_pkg::PATTERN_MAX + $urandom_range(1, 3); i++) begin
         r = $urandom_range(0, 99);
         offer_item(wpm_pkg::MODE_APPEND,
                    r < 70 ? wpm_pkg::QMARK_BYTE :
                    r < 85 ? wpm_pkg::STAR_BYTE : pick_glob_byte());
      end
      for (int i = 0; i < wpm_pkg::PATTERN_MAX + $urandom_range(0, 4); i++)
         offer_item(wpm_pkg::MODE_TEXT, pick_text_byte());
   endtask

   // Receiver: random stalls, calm stretches, and one long hold-off
   initial begin : receiver
      int  stall, calm, seen, r;
      bit  held;
      stall = 0;
      calm  = 0;
      seen  = 0;
      held  = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) seen++;
         r = $urandom_range(0, 99);
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (!held && seen >= 120) begin
            held  = 1'b1;
            stall = 150;
            rsp_ready <= 1'b0;
         end else if (calm > 0) begin
            calm--;
            rsp_ready <= 1'b1;
         end else if (r < 3) begin
            calm = 50;
            rsp_ready <= 1'b1;
         end else if (r < 70) begin
            rsp_ready <= 1'b1;
         end else if (r < 96) begin
            stall = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            stall = $urandom_range(5, 25);
            rsp_ready <= 1'b0;
         end
      end
   end

   // Stimulus and verdict
   initial begin : stimulus
      int  r, fills;
      bit  paused;
      fills  = 0;
      paused = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pattern, field extremes, stars and question marks in
      // both pattern and text, and the unused mode
      offer_item(wpm_pkg::MODE_CLEAR, 8'h00);
      offer_item(wpm_pkg::MODE_TEXT, 8'h61);
      offer_item(wpm_pkg::MODE_IDLE, 8'hFF);
      offer_item(wpm_pkg::MODE_APPEND, wpm_pkg::STAR_BYTE);
      offer_item(wpm_pkg::MODE_TEXT, wpm_pkg::STAR_BYTE);
      offer_item(wpm_pkg::MODE_TEXT, 8'hFF);
      offer_item(wpm_pkg::MODE_APPEND, wpm_pkg::QMARK_BYTE);
      offer_item(wpm_pkg::MODE_TEXT, wpm_pkg::QMARK_BYTE);
      offer_item(wpm_pkg::MODE_TEXT, 8'h00);
      offer_item(wpm_pkg::MODE_CLEAR, 8'hFF);
      offer_item(wpm_pkg::MODE_APPEND, 8'h00);
      offer_item(wpm_pkg::MODE_APPEND, 8'hFF);
      offer_item(wpm_pkg::MODE_TEXT, 8'h00);
      offer_item(wpm_pkg::MODE_TEXT, 8'hFF);
      offer_item(wpm_pkg::MODE_TEXT, 8'hFF);
      offer_item(wpm_pkg::MODE_APPEND, wpm_pkg::STAR_BYTE);
      offer_item(wpm_pkg::MODE_TEXT, 8'h00);
      offer_item(wpm_pkg::MODE_TEXT, 8'hFF);
      offer_item(wpm_pkg::MODE_TEXT, wpm_pkg::STAR_BYTE);
      offer_item(wpm_pkg::MODE_IDLE, 8'h00);
      offer_item(wpm_pkg::MODE_CLEAR, wpm_pkg::STAR_BYTE);
      offer_item(wpm_pkg::MODE_APPEND, wpm_pkg::QMARK_BYTE);
      offer_item(wpm_pkg::MODE_TEXT, wpm_pkg::STAR_BYTE);
      offer_item(wpm_pkg::MODE_APPEND, 8'h61);
      offer_item(wpm_pkg::MODE_TEXT, 8'h61);
      drain();

      // Random: mostly well-formed sessions, some fills, noise and junk text
      burst = 1'b1;
      run_fill_session();
      burst = 1'b0;
      fills = 1;
      while (items_sent < ITEM_TARGET) begin
         if (!paused && items_sent >= ITEM_TARGET / 2) begin
            paused = 1'b1;
            drain();
         end
         burst = ($urandom_range(0, 9) == 0);
         r = $urandom_range(0, 99);
         if (r < 60) begin
            run_glob_session(1'b0, 1'b0);
         end else if (r < 70) begin
            run_glob_session(1'b1, 1'b0);
         end else if (r < 74 && fills < 3) begin
            run_fill_session();
            fills++;
         end else if (r < 90) begin
            repeat ($urandom_range(1, 6))
               offer_item(wpm_pkg::wpm_mode_type'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)));
         end else begin
            run_glob_session(1'b0, 1'b1);
         end
      end
      burst = 1'b0;
      drain();
      repeat (4) @(posedge clock);

      $display("Covered %0d items: %0d pattern bytes, %0d text bytes, %0d unused-mode items",
               items_sent + idle_sent, append_sent, text_sent, idle_sent);
      $display("Checked %0d responses: %0d matched, %0d dropped appends",
               results_checked, match_count, overflow_count);
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
